@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ sv/srt_pkg.sv @@
`timescale 1ns / 1ps
package srt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;

	// operation codes
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_MISS   = 2'd1,
		ST_EXISTS = 2'd2,
		ST_FULL   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ORD_LT,
		ORD_EQ,
		ORD_GT
	} ord_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_CHK,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_SH_CHK,
		S_SH_RD,
		S_SH_WR,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] dest_prefix_high;
		logic [63:0] dest_prefix_low;
		logic [7:0]  dest_length;
		logic [63:0] source_prefix_high;
		logic [63:0] source_prefix_low;
		logic [7:0]  source_length;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] position;
		logic [8:0] entry_count;
	} rsp_t;

	// one stored key
	typedef struct packed {
		logic [63:0] dh;
		logic [63:0] dl;
		logic [63:0] sh;
		logic [63:0] sl;
		logic [7:0]  dlen;
		logic [7:0]  slen;
	} key_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  srch_rd;
		logic  srch_cmp;
		logic  sh_init;
		logic  sh_rd;
		logic  sh_wr;
		logic  put_key;
		logic  cnt_dec;
		logic  emit;
		stat_t code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       found;
		logic       search_more;
		logic       full;
		logic       shift_more;
	} sts_t;

	// order of probe key p relative to stored entry e
	function automatic ord_t key_order(key_t p, key_t e);
		ord_t r;
		if (p.slen == 8'd0 && e.slen != 8'd0) r = ORD_GT;
		else if (p.slen != 8'd0 && e.slen == 8'd0) r = ORD_LT;
		else if (p.dh != e.dh) r = (p.dh < e.dh) ? ORD_LT : ORD_GT;
		else if (p.dl != e.dl) r = (p.dl < e.dl) ? ORD_LT : ORD_GT;
		else if (p.dlen != e.dlen) r = (p.dlen < e.dlen) ? ORD_LT : ORD_GT;
		else if (p.slen == 8'd0) r = ORD_EQ;
		else if (p.sh != e.sh) r = (p.sh < e.sh) ? ORD_LT : ORD_GT;
		else if (p.sl != e.sl) r = (p.sl < e.sl) ? ORD_LT : ORD_GT;
		else if (p.slen != e.slen) r = (p.slen < e.slen) ? ORD_LT : ORD_GT;
		else r = ORD_EQ;
		return r;
	endfunction

endpackage

@@ sv/srt_ctl.sv @@
`timescale 1ns / 1ps
module srt_ctl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  srt_pkg::sts_t sts,
	output srt_pkg::cmd_t cmd
);
	import srt_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.code = ST_OK;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (sts.found || !sts.search_more) state_d = S_DECIDE;
				else state_d = S_SRCH_RD;
			end
			S_SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				state_d = S_SRCH_CHK;
			end
			S_DECIDE: begin
				priority if (sts.op == OP_INSERT) begin
					if (sts.found) begin
						cmd.emit = 1'b1;
						cmd.code = ST_EXISTS;
						state_d = S_OUT;
					end else if (sts.full) begin
						cmd.emit = 1'b1;
						cmd.code = ST_FULL;
						state_d = S_OUT;
					end else begin
						cmd.sh_init = 1'b1;
						state_d = S_SH_CHK;
					end
				end else if (sts.op == OP_REMOVE && sts.found) begin
					cmd.sh_init = 1'b1;
					state_d = S_SH_CHK;
				end else begin
					// lookup, unknown code, or remove miss
					cmd.emit = 1'b1;
					cmd.code = sts.found ? ST_OK : ST_MISS;
					state_d = S_OUT;
				end
			end
			S_SH_CHK: begin
				if (sts.shift_more) begin
					state_d = S_SH_RD;
				end else begin
					if (sts.op == OP_INSERT) cmd.put_key = 1'b1;
					else cmd.cnt_dec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_SH_RD: begin
				cmd.sh_rd = 1'b1;
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d = S_SH_CHK;
			end
			S_FIN: begin
				cmd.emit = 1'b1;
				cmd.code = ST_OK;
				state_d = S_OUT;
			end
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ sv/srt_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srt_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  srt_pkg::req_t req,
	input  srt_pkg::cmd_t cmd,
	output srt_pkg::sts_t sts,
	output srt_pkg::rsp_t rsp
);
	import srt_pkg::*;

	key_t              mem [TABLE_DEPTH];
	key_t              rdata_q;
	key_t              key_q;
	logic [1:0]        op_q;
	logic [CNT_W-1:0]  count_q, lo_q, hi_q, idx_q, mid;
	logic [CNT_W:0]    mid_sum;
	logic              found_q;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	key_t              wr_data;
	ord_t              ord;
	rsp_t              rsp_q;

	// search midpoint and probe order
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CNT_W:1];
	assign ord = key_order(key_q, rdata_q);

	// memory port selection
	always_comb begin
		rd_en = cmd.srch_rd | cmd.sh_rd;
		if (cmd.srch_rd) rd_addr = mid[ADDR_W-1:0];
		else if (op_q == OP_INSERT) rd_addr = ADDR_W'(idx_q - CNT_W'(1));
		else rd_addr = ADDR_W'(idx_q + CNT_W'(1));
		wr_en = cmd.sh_wr | cmd.put_key;
		wr_addr = cmd.put_key ? lo_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
		wr_data = cmd.put_key ? key_q : rdata_q;
	end

	// key store
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// captured item key
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.operation;
			key_q.dh <= req.dest_prefix_high;
			key_q.dl <= req.dest_prefix_low;
			key_q.dlen <= req.dest_length;
			key_q.slen <= req.source_length;
			key_q.sh <= (req.source_length == 8'd0) ? 64'd0 : req.source_prefix_high;
			key_q.sl <= (req.source_length == 8'd0) ? 64'd0 : req.source_prefix_low;
		end
	end

	// search bounds, shift index and key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				lo_q <= '0;
				hi_q <= count_q;
				found_q <= 1'b0;
			end
			if (cmd.srch_cmp) begin
				unique case (ord)
					ORD_EQ: begin
						lo_q <= mid;
						found_q <= 1'b1;
					end
					ORD_LT: hi_q <= mid;
					ORD_GT: lo_q <= mid + CNT_W'(1);
					default: hi_q <= lo_q;
				endcase
			end
			if (cmd.sh_init) idx_q <= (op_q == OP_INSERT) ? count_q : lo_q;
			if (cmd.sh_wr) begin
				if (op_q == OP_INSERT) idx_q <= idx_q - CNT_W'(1);
				else idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.put_key) count_q <= count_q + CNT_W'(1);
			if (cmd.cnt_dec) count_q <= count_q - CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status <= cmd.code;
			rsp_q.position <= (32'(lo_q) > 32'd255) ? 8'hFF : 8'(lo_q);
			rsp_q.entry_count <= (32'(count_q) > 32'd511) ? 9'h1FF : 9'(count_q);
		end
	end
	assign rsp = rsp_q;

	// status to controller
	always_comb begin
		sts.op = op_q;
		sts.found = found_q;
		sts.search_more = lo_q < hi_q;
		sts.full = 32'(count_q) >= TABLE_DEPTH;
		if (op_q == OP_INSERT) sts.shift_more = idx_q > lo_q;
		else sts.shift_more = (idx_q + CNT_W'(1)) < count_q;
	end

	`ASSERT_NEVER(a_count_bound, 32'(count_q) > TABLE_DEPTH)
	`ASSERT_NEVER(a_search_bounds, cmd.srch_cmp && lo_q >= hi_q)
	`ASSERT_CLK(a_put_room, cmd.put_key |-> 32'(count_q) < TABLE_DEPTH)
	`ASSERT_CLK(a_dec_nonempty, cmd.cnt_dec |-> (found_q && count_q != '0))

endmodule

@@ sv/sorted_prefix_slot_table.sv @@
`timescale 1ns / 1ps
// Sorted route key table with binary search, insert and remove.
// Request channel req_valid/req_ready/req carries one item: an operation
// (lookup, insert, remove) and a route key. Response channel
// rsp_valid/rsp_ready/rsp returns exactly one item per request: status,
// position (hit index or insertion point) and the key count afterwards.
// One item is worked at a time; req_ready is high only when idle.
// From the accepting edge the block runs a binary search; each probe is a
// read of the key store and a compare (at most 9 probes for 256 entries).
// An insert or remove that changes the table then shifts entries, each
// with a read and a write, before the key is put in or the count lowered.
// The single read and single write port of the key store sets the probe
// and shift cost. After the response is taken the block returns to idle
// before it accepts the next item.
// The result sits in an output register; a stalled receiver holds rsp and
// rsp_valid steady and the block takes no new item until it is taken.
// Reset empties the table at once (key count zero); stored keys are not
// cleared, as only entries below the count are ever read.
module sorted_prefix_slot_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  srt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output srt_pkg::rsp_t rsp
);
	import srt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	srt_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// key store and search datapath
	srt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
